// ===== rtl/pw2s_pkg.sv =====
`timescale 1ns / 1ps
package pw2s_pkg;

    localparam int REL_W   = 27;
    localparam int PROD_W  = 43;
    localparam int ACC_W   = 45;
    localparam int CLIP_W  = 41;
    localparam int NUM_W   = 42;
    localparam int QBITS   = 33;
    localparam int REM_W   = 42;
    localparam int MAG_W   = 58;
    localparam int PIPE_LAT = 41;

    localparam logic [3:0] REG_ROW0     = 4'd0;
    localparam logic [3:0] REG_ROW1     = 4'd1;
    localparam logic [3:0] REG_ROW2     = 4'd2;
    localparam logic [3:0] REG_ROW3     = 4'd3;
    localparam logic [3:0] REG_CAM_X    = 4'd4;
    localparam logic [3:0] REG_CAM_Y    = 4'd5;
    localparam logic [3:0] REG_CAM_Z    = 4'd6;
    localparam logic [3:0] REG_VIEWPORT = 4'd7;

    localparam logic signed [CLIP_W-1:0] BEHIND_LIMIT = 41'sd6;
    localparam logic signed [CLIP_W-1:0] FORCED_W     = 41'sd66;

    typedef struct packed {
        logic behind;
        logic outside;
    } flags_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] nx;
        logic signed [NUM_W-1:0] ny;
        logic [CLIP_W-1:0]       w;
        flags_t                  flags;
    } clip_t;

    function automatic logic signed [15:0] coef(input logic [63:0] row, input int col);
        coef = row[16*col +: 16];
    endfunction

endpackage

// ===== rtl/perspective_world_to_screen.sv =====
`timescale 1ns / 1ps
// Projects one world point per clock to viewport pixels. A point is taken whenever start
// is high (busy stays low) and its result appears with done, one result per point, in
// order. A point passes through the 4-stage matrix transform and then the divide
// pipeline, which resolves one quotient bit per stage over 33 stages. The result ports
// carry a value for one cycle only and the receiver cannot stall them. Write the
// configuration registers only while no point is in flight.
module perspective_world_to_screen
    import pw2s_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [25:0]  world_x,
    input  logic signed [25:0]  world_y,
    input  logic signed [25:0]  world_z,
    output logic                done,
    output logic signed [31:0]  screen_x,
    output logic signed [31:0]  screen_y,
    output logic                behind_camera,
    output logic                outside_depth,
    output logic                visible,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    logic [63:0]        row_reg [4];
    logic signed [25:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [31:0]        viewport_reg;

    logic   clip_valid;
    clip_t  clip;
    logic   x_valid, y_valid;
    flags_t x_flags, y_flags;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= 64'h0000_0000_0000_1000;
            row_reg[1]   <= 64'h0000_0000_1000_0000;
            row_reg[2]   <= 64'h0000_1000_0000_0000;
            row_reg[3]   <= 64'h1000_0000_0000_0000;
            cam_x_reg    <= '0;
            cam_y_reg    <= '0;
            cam_z_reg    <= '0;
            viewport_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW0:     row_reg[0]   <= cfg_data;
                REG_ROW1:     row_reg[1]   <= cfg_data;
                REG_ROW2:     row_reg[2]   <= cfg_data;
                REG_ROW3:     row_reg[3]   <= cfg_data;
                REG_CAM_X:    cam_x_reg    <= cfg_data[25:0];
                REG_CAM_Y:    cam_y_reg    <= cfg_data[25:0];
                REG_CAM_Z:    cam_z_reg    <= cfg_data[25:0];
                REG_VIEWPORT: viewport_reg <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    pw2s_transform u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z),
        .row       (row_reg),
        .cam_x     (cam_x_reg),
        .cam_y     (cam_y_reg),
        .cam_z     (cam_z_reg),
        .out_valid (clip_valid),
        .out_clip  (clip)
    );

    pw2s_divider u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clip_valid),
        .num       (clip.nx),
        .scale     (viewport_reg[15:0]),
        .den       (clip.w),
        .in_flags  (clip.flags),
        .out_valid (x_valid),
        .result    (screen_x),
        .out_flags (x_flags)
    );

    pw2s_divider u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clip_valid),
        .num       (clip.ny),
        .scale     (viewport_reg[31:16]),
        .den       (clip.w),
        .in_flags  (clip.flags),
        .out_valid (y_valid),
        .result    (screen_y),
        .out_flags (y_flags)
    );

    assign done          = x_valid && y_valid;
    assign behind_camera = x_flags.behind;
    assign outside_depth = x_flags.outside && !y_flags.behind && y_flags.outside
                         || x_flags.outside && y_flags.behind;
    assign visible       = !behind_camera && !outside_depth;

endmodule

// ===== rtl/pw2s_transform.sv =====
`timescale 1ns / 1ps
module pw2s_transform
    import pw2s_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [25:0]  world_x,
    input  logic signed [25:0]  world_y,
    input  logic signed [25:0]  world_z,
    input  logic [63:0]         row [4],
    input  logic signed [25:0]  cam_x,
    input  logic signed [25:0]  cam_y,
    input  logic signed [25:0]  cam_z,
    output logic                out_valid,
    output clip_t               out_clip
);

    logic [3:0] valid_reg;
    logic signed [REL_W-1:0]  rel_reg  [3];
    logic signed [PROD_W-1:0] prod_reg [3][4];
    logic signed [CLIP_W-1:0] clip_reg [4];
    clip_t                    out_reg;

    logic signed [PROD_W-1:0] prod_next [3][4];
    logic signed [ACC_W-1:0]  acc_next  [4];
    logic signed [CLIP_W-1:0] clip_next [4];
    clip_t                    out_next;
    logic                     behind;
    logic signed [CLIP_W-1:0] w_eff;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] = rel_reg[r] * coef(row[r], c);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            acc_next[c] = ACC_W'(prod_reg[0][c]) + ACC_W'(prod_reg[1][c])
                        + ACC_W'(prod_reg[2][c]) + (ACC_W'(coef(row[3], c)) <<< 8);
            // floor to Q.16
            clip_next[c] = acc_next[c][ACC_W-1:4];
        end
    end

    always_comb
    begin
        behind = (clip_reg[3] <= BEHIND_LIMIT);
        w_eff  = behind ? FORCED_W : clip_reg[3];
        out_next.flags.behind  = behind;
        out_next.flags.outside = clip_reg[2][CLIP_W-1] || (clip_reg[2] > w_eff);
        out_next.nx = NUM_W'(clip_reg[0]) + NUM_W'(w_eff);
        out_next.ny = NUM_W'(w_eff) - NUM_W'(clip_reg[1]);
        out_next.w  = w_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg[0] <= REL_W'(world_x) - REL_W'(cam_x);
        rel_reg[1] <= REL_W'(world_y) - REL_W'(cam_y);
        rel_reg[2] <= REL_W'(world_z) - REL_W'(cam_z);
        prod_reg   <= prod_next;
        clip_reg   <= clip_next;
        out_reg    <= out_next;
    end

    assign out_valid = valid_reg[3];
    assign out_clip  = out_reg;

endmodule

// ===== rtl/pw2s_divider.sv =====
`timescale 1ns / 1ps
module pw2s_divider
    import pw2s_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [NUM_W-1:0]  num,
    input  logic [15:0]              scale,
    input  logic [CLIP_W-1:0]        den,
    input  flags_t                   in_flags,
    output logic                     out_valid,
    output logic signed [31:0]       result,
    output flags_t                   out_flags
);

    localparam int PW = NUM_W + 17;

    // front stages: multiply, magnitude, overflow check
    logic [1:0]              fv_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [CLIP_W-1:0]       w0_reg, w1_reg;
    flags_t                  f0_reg, f1_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        mag_reg;

    // long division stages, index 0 is the entry
    logic [QBITS:0]          dv_reg;
    logic [REM_W-1:0]        rem_reg  [QBITS+1];
    logic [QBITS-1:0]        low_reg  [QBITS+1];
    logic [QBITS-1:0]        q_reg    [QBITS+1];
    logic [CLIP_W-1:0]       w_reg    [QBITS+1];
    logic                    neg_s    [QBITS+1];
    logic                    ovf_reg  [QBITS+1];
    flags_t                  fl_reg   [QBITS+1];

    logic [REM_W-1:0]        try_rem  [QBITS];
    logic                    fits     [QBITS];

    logic                    out_valid_reg;
    logic signed [31:0]      result_reg;
    flags_t                  out_flags_reg;

    logic signed [PW-1:0]    prod_next;
    logic [MAG_W-1:0]        mag_next;
    logic [31:0]             top_bits;
    logic [QBITS:0]          q_up;
    logic signed [31:0]      result_next;

    always_comb
    begin
        prod_next = PW'(num) * PW'($signed({1'b0, scale}));
        mag_next  = prod_reg[PW-1] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
        top_bits  = mag_reg[MAG_W-1:26];
        for (int i = 0; i < QBITS; i++)
        begin
            try_rem[i] = {rem_reg[i][REM_W-2:0], low_reg[i][QBITS-1]};
            fits[i]    = try_rem[i] >= REM_W'(w_reg[i]);
        end
    end

    always_comb
    begin
        q_up = {1'b0, q_reg[QBITS]} + (QBITS+1)'(rem_reg[QBITS] != '0);
        if (!neg_s[QBITS])
        begin
            if (ovf_reg[QBITS] || q_reg[QBITS][QBITS-1:31] != '0)
                result_next = 32'sh7FFFFFFF;
            else
                result_next = $signed(q_reg[QBITS][31:0]);
        end
        else
        begin
            if (ovf_reg[QBITS] || q_up > (QBITS+1)'(33'h080000000))
                result_next = 32'sh80000000;
            else
                result_next = -$signed(q_up[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg        <= '0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fv_reg        <= {fv_reg[0], in_valid};
            dv_reg        <= {dv_reg[QBITS-1:0], fv_reg[1]};
            out_valid_reg <= dv_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        w0_reg   <= den;
        f0_reg   <= in_flags;
        neg_reg  <= prod_reg[PW-1];
        mag_reg  <= mag_next;
        w1_reg   <= w0_reg;
        f1_reg   <= f0_reg;

        // numerator is mag * 128; quotient needs 33 bits or it saturates
        rem_reg[0] <= REM_W'(top_bits);
        low_reg[0] <= {mag_reg[25:0], 7'b0};
        q_reg[0]   <= '0;
        w_reg[0]   <= w1_reg;
        neg_s[0]   <= neg_reg;
        ovf_reg[0] <= REM_W'(top_bits) >= REM_W'(w1_reg);
        fl_reg[0]  <= f1_reg;

        for (int i = 0; i < QBITS; i++)
        begin
            rem_reg[i+1] <= fits[i] ? try_rem[i] - REM_W'(w_reg[i]) : try_rem[i];
            low_reg[i+1] <= {low_reg[i][QBITS-2:0], 1'b0};
            q_reg[i+1]   <= {q_reg[i][QBITS-2:0], fits[i]};
            w_reg[i+1]   <= w_reg[i];
            neg_s[i+1]   <= neg_s[i];
            ovf_reg[i+1] <= ovf_reg[i];
            fl_reg[i+1]  <= fl_reg[i];
        end

        result_reg    <= result_next;
        out_flags_reg <= fl_reg[QBITS];
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign out_flags = out_flags_reg;

endmodule

// ===== rtl/pw2s_checker.sv =====
`timescale 1ns / 1ps
module pw2s_checker
    import pw2s_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic behind_camera,
    input logic outside_depth,
    input logic visible
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LAT done)
        else $error("transaction result missing after pipeline latency");

    a_visible: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> visible == !(behind_camera || outside_depth))
        else $error("visible disagrees with flags");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a non-stalling pipeline");

endmodule

bind perspective_world_to_screen pw2s_checker u_pw2s_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .behind_camera (behind_camera),
    .outside_depth (outside_depth),
    .visible       (visible)
);

// ===== tb/tb_perspective_world_to_screen.sv =====
`timescale 1ns / 1ps
module tb_perspective_world_to_screen;
    import pw2s_pkg::*;

    typedef struct {
        logic signed [25:0] x;
        logic signed [25:0] y;
        logic signed [25:0] z;
    } point_t;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               behind;
        logic               outside;
        logic               vis;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [25:0] world_x;
    logic signed [25:0] world_y;
    logic signed [25:0] world_z;
    logic               done;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               behind_camera;
    logic               outside_depth;
    logic               visible;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_index;
    logic [63:0]        cfg_data;

    perspective_world_to_screen DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .done(done), .screen_x(screen_x), .screen_y(screen_y),
        .behind_camera(behind_camera), .outside_depth(outside_depth), .visible(visible),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // projection setup mirrored in the testbench
    logic [63:0]        mrow [4];
    logic signed [25:0] cam [3];
    logic [31:0]        vport;

    point_t pending_points[$];
    pixel_t expected_pixels[$];
    int     send_idle_pct;
    int     errors;

    function automatic point_t pt(int x, int y, int z);
        point_t p;
        p.x = 26'(x);
        p.y = 26'(y);
        p.z = 26'(z);
        return p;
    endfunction

    function automatic longint fdiv(longint a, longint d, output longint r);
        longint q;
        q = a / d;
        r = a % d;
        if (r < 0)
        begin
            q -= 1;
            r += d;
        end
        return q;
    endfunction

    function automatic logic signed [31:0] scale_pixel(longint n, longint k, longint w);
        longint q, r, v, r2;
        if (k == 0)
            return 0;
        q = fdiv(n, w, r);
        if (q > (64'sd1 <<< 33))
            return 32'sh7fffffff;
        if (q < -(64'sd1 <<< 33))
            return 32'sh80000000;
        v = q * k + fdiv(r * k, w, r2);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic pixel_t project_point(point_t p);
        pixel_t res;
        longint rel [3];
        longint clip [4];
        longint acc, r, kw, kh;
        logic signed [15:0] c;
        rel[0] = longint'(p.x) - longint'(cam[0]);
        rel[1] = longint'(p.y) - longint'(cam[1]);
        rel[2] = longint'(p.z) - longint'(cam[2]);
        for (int j = 0; j < 4; j++)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                c = mrow[i][16*j +: 16];
                acc += rel[i] * longint'(c);
            end
            c = mrow[3][16*j +: 16];
            acc += longint'(c) * 256;
            clip[j] = fdiv(acc, 16, r);
        end
        res.behind = clip[3] <= 6;
        if (res.behind)
            clip[3] = 66;
        res.outside = clip[2] < 0 || clip[2] > clip[3];
        res.vis = !res.behind && !res.outside;
        kw = longint'(vport[15:0]) * 128;
        kh = longint'(vport[31:16]) * 128;
        res.sx = scale_pixel(clip[0] + clip[3], kw, clip[3]);
        res.sy = scale_pixel(clip[3] - clip[1], kh, clip[3]);
        return res;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            world_x <= 0;
            world_y <= 0;
            world_z <= 0;
        end
        else if (!(start && busy))
        begin
            if (start)
                expected_pixels.push_back(project_point('{world_x, world_y, world_z}));
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                point_t p;
                p = pending_points.pop_front();
                start <= 1;
                world_x <= p.x;
                world_y <= p.y;
                world_z <= p.z;
            end
            else
                start <= 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, screen_x, screen_y);
                errors++;
            end
            else
            begin
                pixel_t e;
                e = expected_pixels.pop_front();
                if (screen_x !== e.sx)
                begin
                    $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, screen_x);
                    errors++;
                end
                if (screen_y !== e.sy)
                begin
                    $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, screen_y);
                    errors++;
                end
                if (behind_camera !== e.behind)
                begin
                    $display("%0t: behind_camera expected %0b actual %0b", $time, e.behind,
                             behind_camera);
                    errors++;
                end
                if (outside_depth !== e.outside)
                begin
                    $display("%0t: outside_depth expected %0b actual %0b", $time, e.outside,
                             outside_depth);
                    errors++;
                end
                if (visible !== e.vis)
                begin
                    $display("%0t: visible expected %0b actual %0b", $time, e.vis, visible);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [63:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        case (idx)
            REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mrow[idx[1:0]] = val;
            REG_CAM_X: cam[0] = val[25:0];
            REG_CAM_Y: cam[1] = val[25:0];
            REG_CAM_Z: cam[2] = val[25:0];
            REG_VIEWPORT: vport = val[31:0];
            default: ;
        endcase
        // leave an idle gap with cfg_valid low before the next transaction
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || start || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    function automatic logic signed [25:0] rand_coord(int mag);
        int v;
        v = $urandom_range(2 * mag) - mag;
        return 26'(v);
    endfunction

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(8192) - 4096);
            default: return 16'($urandom_range(1024) - 512);
        endcase
    endfunction

    task automatic random_setup(int extreme);
        logic [63:0] row;
        for (int r = 0; r < 4; r++)
        begin
            for (int j = 0; j < 4; j++)
                row[16*j +: 16] = extreme ? (($urandom_range(1)) ? 16'h7fff : 16'h8000)
                                          : rand_coef();
            // keep w mostly driven by z for a useful mix of visible points
            if (!extreme && r == 2 && $urandom_range(1))
                row[63:48] = 16'd4096;
            write_reg(4'(r), row);
        end
        for (int i = 0; i < 3; i++)
            write_reg(4'(REG_CAM_X + i),
                      extreme ? (($urandom_range(1)) ? 64'(25600000) : -64'sd25600000)
                              : 64'(signed'(rand_coord(25600))));
        write_reg(REG_VIEWPORT, extreme ? 64'hffffffff : {32'b0, 16'($urandom_range(4096)),
                                                          16'($urandom_range(4096))});
    endtask

    initial
    begin
        int bank;
        point_t p;
        errors = 0;
        send_idle_pct = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        rst_n = 0;
        mrow[0] = 64'd4096;
        mrow[1] = 64'd4096 << 16;
        mrow[2] = 64'd4096 << 32;
        mrow[3] = 64'd4096 << 48;
        cam = '{default: '0};
        vport = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset setup: zero viewport, identity matrix, w stays at 1.0
        pending_points.push_back(pt(0, 0, 0));
        pending_points.push_back(pt(25600000, -25600000, 25600000));
        drain();

        // perspective-like setup: w = z
        write_reg(REG_ROW0, 64'd4096);
        write_reg(REG_ROW1, 64'd4096 << 16);
        write_reg(REG_ROW2, (64'd4096 << 32) | (64'd4096 << 48));
        write_reg(REG_ROW3, 64'd0);
        write_reg(REG_CAM_X, 64'd0);
        write_reg(REG_CAM_Y, 64'd0);
        write_reg(REG_CAM_Z, 64'd0);
        write_reg(REG_VIEWPORT, {32'b0, 16'd1080, 16'd1920});
        pending_points.push_back(pt(256, 256, 512));          // visible
        pending_points.push_back(pt(0, 0, -256));             // behind camera
        pending_points.push_back(pt(0, 0, 0));                // w zero, behind
        pending_points.push_back(pt(100, -100, 1));           // tiny w
        pending_points.push_back(pt(25600000, -25600000, 1)); // saturate
        pending_points.push_back(pt(-25600000, 25600000, 7));
        pending_points.push_back(pt(25600000, 25600000, 25600000));
        pending_points.push_back(pt(-25600000, -25600000, -25600000));
        drain();
        write_reg(REG_ROW3, 64'h0000_f000_0000_0000); // depth offset: clip z lowered by 1.0
        write_reg(REG_VIEWPORT, 64'hffff_ffff);
        pending_points.push_back(pt(256, 256, 512));
        pending_points.push_back(pt(-1, 1, 25600000));
        drain();
        write_reg(4'd9, 64'hdead);  // index beyond the list: ignored
        pending_points.push_back(pt(512, 512, 1024));
        drain();

        for (bank = 0; bank < 12; bank++)
        begin
            random_setup(bank == 3 || bank == 9);
            case (bank % 4)
                0: send_idle_pct = 0;
                1: send_idle_pct = 61;
                2: send_idle_pct = 25;
                default: send_idle_pct = $urandom_range(90);
            endcase
            for (int k = 0; k < 125; k++)
            begin
                case ($urandom_range(2))
                    0: p = '{rand_coord(25600000), rand_coord(25600000), rand_coord(25600000)};
                    1: p = '{rand_coord(4096), rand_coord(4096), rand_coord(4096)};
                    default: p = '{rand_coord(25600) + cam[0], rand_coord(25600) + cam[1],
                                   rand_coord(25600) + cam[2]};
                endcase
                pending_points.push_back(p);
            end
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
